FILE: rtl/sas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg: spare sector allocator shared definitions
// Geometry constants, register codes, request/result types and FSM states.
// ----------------------------------------------------------------------------
package sas_pkg;

   localparam int RELOC_CYLS_DEF  = 3;
   localparam int MAX_TRACKS_DEF  = 32;
   localparam int MAX_SECTORS_DEF = 64;
   localparam int SYSTEM_CYLS     = 5;
   localparam int MAP_CYLS        = 1;
   localparam int MAINT_CYLS      = 1;
   localparam int EDGE_REL        = SYSTEM_CYLS - MAP_CYLS - MAINT_CYLS;

   localparam int CYL_W      = 12;
   localparam int TRK_W      = 5;
   localparam int SEC_W      = 6;
   localparam int TPC_W      = 6;
   localparam int SPT_W      = 7;
   localparam int MODE_W     = 2;
   localparam int OUTCOME_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int REL_W      = 14;

   localparam logic [CYL_W-1:0] CYL_COUNT_RST = 12'd823;
   localparam logic [TPC_W-1:0] TRACKS_RST    = 6'd19;
   localparam logic [SPT_W-1:0] SECTORS_RST   = 7'd32;
   localparam logic             SAME_RULE_RST = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_MARK    = 2'd1,
      MODE_CHECK   = 2'd2,
      MODE_REPLACE = 2'd3
   } mode_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_DONE     = 3'd0,
      OUT_SPARE    = 3'd1,
      OUT_IN_PLACE = 3'd2,
      OUT_MAP      = 3'd3,
      OUT_NONE     = 3'd4
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CYL_COUNT = 2'd0,
      CSR_TRACKS    = 2'd1,
      CSR_SECTORS   = 2'd2,
      CSR_SAME_RULE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RMW_READ,
      ST_RMW_UPDATE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CYL_W-1:0] cyl_count;
      logic [TPC_W-1:0] tracks;
      logic [SPT_W-1:0] sectors;
      logic             same_rule;
   } cfg_type;

   typedef struct packed {
      mode_type         mode;
      logic [CYL_W-1:0] cylinder;
      logic [TRK_W-1:0] track;
      logic [SEC_W-1:0] sector;
      logic             whole_track;
   } item_type;

   typedef struct packed {
      outcome_type      outcome;
      logic             collides;
      logic [CYL_W-1:0] spare_cylinder;
      logic [TRK_W-1:0] spare_track;
      logic [SEC_W-1:0] spare_sector;
   } result_type;

endpackage

FILE: rtl/sas_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_row_mem: spare usage row memory
// One row of sector used bits per spare track, registered read, one write
// port, and a valid bit per row so that a bulk clear resets every row at once.
// ----------------------------------------------------------------------------
module sas_row_mem import sas_pkg::*; #(
   parameter int ROWS  = RELOC_CYLS_DEF * MAX_TRACKS_DEF,
   parameter int WIDTH = MAX_SECTORS_DEF,
   parameter int AW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] row_mem_ff [ROWS];
   logic [ROWS-1:0]  valid_ff;
   logic [WIDTH-1:0] rd_q_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= row_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

FILE: rtl/sas_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_engine: spare sector allocator sequencer
// Decodes a request, clears the rows, checks or read-modify-writes one row, or
// runs a pipelined scan of the rows in use up to a hit, and builds the result.
// ----------------------------------------------------------------------------
module sas_engine import sas_pkg::*; #(
   parameter int RELOC_CYLS  = RELOC_CYLS_DEF,
   parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
   parameter int MAX_SECTORS = MAX_SECTORS_DEF,
   parameter int ROWS        = RELOC_CYLS * MAX_TRACKS,
   parameter int RW          = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  item_type               item,
   input  logic                   slot_free,
   output logic                   res_load,
   output result_type             res,
   output logic                   mem_clear,
   output logic                   mem_rd_en,
   output logic [RW-1:0]          mem_rd_addr,
   input  logic [MAX_SECTORS-1:0] mem_rd_data,
   output logic                   mem_wr_en,
   output logic [RW-1:0]          mem_wr_addr,
   output logic [MAX_SECTORS-1:0] mem_wr_data
);

   localparam int TW  = $clog2(MAX_TRACKS + 1);
   localparam int CW  = $clog2(RELOC_CYLS + 1);
   localparam int EW  = $clog2(MAX_SECTORS + 1);
   localparam int PW  = CW + TW + TRK_W;
   localparam int MS  = MAX_SECTORS;
   localparam logic signed [REL_W-1:0] REL_OFS  = REL_W'(SYSTEM_CYLS);
   localparam logic signed [REL_W-1:0] EDGE_S   = REL_W'(EDGE_REL);
   localparam logic signed [REL_W-1:0] RELOC_S  = REL_W'(RELOC_CYLS);
   localparam logic signed [REL_W-1:0] ZERO_S   = '0;

   state_type  state_ff, state_in;
   item_type   item_ff, item_in;
   result_type res_ff, res_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] iss_row_ff, iss_row_in;
   logic [TW-1:0] iss_trk_ff, iss_trk_in;
   logic [CW-1:0] iss_cyl_ff, iss_cyl_in;
   logic          iss_done_ff, iss_done_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [RW-1:0] chk_row_ff, chk_row_in;
   logic [TW-1:0] chk_trk_ff, chk_trk_in;
   logic [CW-1:0] chk_cyl_ff, chk_cyl_in;
   logic          chk_last_ff, chk_last_in;

   logic [TW-1:0]           eff_trk;
   logic [EW-1:0]           eff_sec;
   logic [MS-1:0]           full;
   logic signed [REL_W-1:0] rel;
   logic                    in_area, trk_ok, sec_ok, spare_ok;
   logic                    in_place, at_edge, map_area, scan_ok;
   logic [PW-1:0]           row_prod;
   logic [RW-1:0]           row_calc;
   logic [MS-1:0]           sec_mask, free_bits, first_mask, upd_mask;
   logic [SEC_W-1:0]        first_idx;
   logic                    hit_whole, hit_same, hit_first, hit;
   logic                    iss_last;
   logic [CYL_W-1:0]        scan_cyl;

   // geometry
   always_comb begin
      if (8'(cfg.tracks) > 8'(MAX_TRACKS)) begin
         eff_trk = TW'(MAX_TRACKS);
      end else begin
         eff_trk = TW'(cfg.tracks);
      end
      if (8'(cfg.sectors) > 8'(MAX_SECTORS)) begin
         eff_sec = EW'(MAX_SECTORS);
      end else begin
         eff_sec = EW'(cfg.sectors);
      end
      for (int i = 0; i < MS; i++) begin
         full[i] = (EW'(i) < eff_sec);
      end
   end

   // address decode
   always_comb begin
      rel      = $signed({2'b00, item_ff.cylinder}) - $signed({2'b00, cfg.cyl_count}) + REL_OFS;
      in_area  = (rel >= ZERO_S) && (rel < RELOC_S);
      trk_ok   = 8'(item_ff.track) < 8'(eff_trk);
      sec_ok   = 8'(item_ff.sector) < 8'(MAX_SECTORS);
      spare_ok = in_area && trk_ok && (item_ff.whole_track || sec_ok);
      in_place = (rel >= ZERO_S) && (rel < EDGE_S);
      at_edge  = (rel == EDGE_S);
      map_area = (rel >= ZERO_S) && !in_place && !at_edge;
      scan_ok  = (eff_trk != '0) &&
                 (item_ff.whole_track || !cfg.same_rule || sec_ok);
      row_prod = PW'(rel[CW-1:0]) * PW'(eff_trk) + PW'(item_ff.track);
      row_calc = row_prod[RW-1:0];
   end

   // row checks on read data
   always_comb begin
      sec_mask   = MS'(1) << item_ff.sector;
      free_bits  = ~mem_rd_data & full;
      first_idx  = '0;
      for (int i = MS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            first_idx = SEC_W'(i);
         end
      end
      first_mask = MS'(1) << first_idx;
      hit_whole  = ~|(mem_rd_data & full);
      hit_same   = ~|(mem_rd_data & sec_mask);
      hit_first  = |free_bits;
      upd_mask   = item_ff.whole_track ? full : sec_mask;
      if (item_ff.whole_track) begin
         hit = chk_valid_ff && hit_whole;
      end else if (cfg.same_rule) begin
         hit = chk_valid_ff && hit_same;
      end else begin
         hit = chk_valid_ff && hit_first;
      end
      iss_last = (iss_trk_ff == TW'(eff_trk - 1'b1)) && (iss_cyl_ff == CW'(RELOC_CYLS - 1));
      scan_cyl = cfg.cyl_count + CYL_W'(chk_cyl_ff) - CYL_W'(SYSTEM_CYLS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         iss_done_ff  <= 1'b1;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         iss_done_ff  <= iss_done_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      row_ff      <= row_in;
      iss_row_ff  <= iss_row_in;
      iss_trk_ff  <= iss_trk_in;
      iss_cyl_ff  <= iss_cyl_in;
      chk_row_ff  <= chk_row_in;
      chk_trk_ff  <= chk_trk_in;
      chk_cyl_ff  <= chk_cyl_in;
      chk_last_ff <= chk_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      row_in       = row_ff;
      iss_row_in   = iss_row_ff;
      iss_trk_in   = iss_trk_ff;
      iss_cyl_in   = iss_cyl_ff;
      iss_done_in  = iss_done_ff;
      chk_valid_in = 1'b0;
      chk_row_in   = chk_row_ff;
      chk_trk_in   = chk_trk_ff;
      chk_cyl_in   = chk_cyl_ff;
      chk_last_in  = chk_last_ff;
      req_ready    = 1'b0;
      res_load     = 1'b0;
      mem_clear    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = row_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = row_ff;
      mem_wr_data  = mem_rd_data | upd_mask;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = item;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_in      = '0;
            row_in      = row_calc;
            iss_row_in  = '0;
            iss_trk_in  = '0;
            iss_cyl_in  = '0;
            iss_done_in = 1'b0;
            state_in    = ST_FINISH;
            case (item_ff.mode)
               MODE_CLEAR: begin
                  mem_clear = 1'b1;
               end
               MODE_MARK, MODE_CHECK: begin
                  if (spare_ok) begin
                     state_in = ST_RMW_READ;
                  end
               end
               MODE_REPLACE: begin
                  if (in_place || map_area) begin
                     res_in.outcome        = in_place ? OUT_IN_PLACE : OUT_MAP;
                     res_in.spare_cylinder = item_ff.cylinder;
                     res_in.spare_track    = item_ff.track;
                     res_in.spare_sector   = item_ff.sector;
                     if (in_place && spare_ok) begin
                        state_in = ST_RMW_READ;
                     end
                  end else begin
                     res_in.outcome = OUT_NONE;
                     if (scan_ok) begin
                        state_in = ST_SCAN;
                     end
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_RMW_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_RMW_UPDATE;
         end
         ST_RMW_UPDATE: begin
            if (item_ff.mode == MODE_CHECK) begin
               res_in.collides = |(mem_rd_data & upd_mask);
            end else begin
               mem_wr_en = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (!iss_done_ff && !hit) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = iss_row_ff;
               chk_valid_in = 1'b1;
               chk_row_in   = iss_row_ff;
               chk_trk_in   = iss_trk_ff;
               chk_cyl_in   = iss_cyl_ff;
               chk_last_in  = iss_last;
               if (iss_last) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_row_in = iss_row_ff + 1'b1;
                  if (iss_trk_ff == TW'(eff_trk - 1'b1)) begin
                     iss_trk_in = '0;
                     iss_cyl_in = iss_cyl_ff + 1'b1;
                  end else begin
                     iss_trk_in = iss_trk_ff + 1'b1;
                  end
               end
            end
            if (hit) begin
               mem_wr_en             = 1'b1;
               mem_wr_addr           = chk_row_ff;
               res_in.outcome        = OUT_SPARE;
               res_in.spare_cylinder = scan_cyl;
               res_in.spare_track    = TRK_W'(chk_trk_ff);
               if (item_ff.whole_track) begin
                  mem_wr_data         = mem_rd_data | full;
                  res_in.spare_sector = '0;
               end else if (cfg.same_rule) begin
                  mem_wr_data         = mem_rd_data | sec_mask;
                  res_in.spare_sector = item_ff.sector;
               end else begin
                  mem_wr_data         = mem_rd_data | first_mask;
                  res_in.spare_sector = first_idx;
               end
               state_in = ST_FINISH;
            end else if (chk_valid_ff && chk_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   a_no_same_row_rw: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("read and write of one row in the same cycle");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_valid_ff) |-> $past(mem_rd_en))
      else $error("scan check without a preceding read");

   a_write_ends_item: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> (state_ff == ST_FINISH))
      else $error("row write not followed by finish");

   a_clear_ends_item: assert property (@(posedge clock) disable iff (reset)
      mem_clear |=> (state_ff == ST_FINISH && res_ff.outcome == OUT_DONE))
      else $error("clear not followed by done result");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (!mem_rd_en || mem_rd_addr < ROWS) && (!mem_wr_en || mem_wr_addr < ROWS))
      else $error("row address beyond the spare area");

endmodule

FILE: rtl/spare_sector_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spare_sector_allocator_top: spare sector allocator
// Tracks used/free sectors of the spare relocation cylinders and serves
// clear, mark, collision check and replacement requests.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: mode, cylinder, track, sector
//                                             tuser: whole_track
//  rsp      out        rsp_tvalid/rsp_tready  tdata: collides, spare address
//                                             tuser: outcome
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
//  Replacement with a scan reads one row per cycle from the row memory, over
//  up to effective tracks * RELOC_CYLS rows (57 at reset geometry, 96 at most).
//  Reset clears all row valid bits at once; no clearing pass is needed.
//  A new request is taken while a result waits in the output register; the
//  engine then holds its result until that register drains.
// ----------------------------------------------------------------------------
module spare_sector_allocator_top import sas_pkg::*; #(
   parameter int RELOC_CYLS  = RELOC_CYLS_DEF,
   parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
   parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] mode, [13:2] cylinder, [18:14] track, [24:19] sector, [31:25] zero
   input  logic [31:0]           req_tdata,
   // [0] whole_track
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] collides, [12:1] spare_cylinder, [17:13] spare_track, [23:18] spare_sector
   output logic [23:0]           rsp_tdata,
   // [2:0] outcome
   output logic [OUTCOME_W-1:0]  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ROWS = RELOC_CYLS * MAX_TRACKS;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   cfg_type    cfg_ff;
   item_type   item;
   result_type res;
   result_type rsp_res_ff;
   logic       rsp_valid_ff;
   logic       slot_free, res_load;
   logic       mem_clear, mem_rd_en, mem_wr_en;
   logic [RW-1:0]          mem_rd_addr, mem_wr_addr;
   logic [MAX_SECTORS-1:0] mem_rd_data, mem_wr_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cyl_count <= CYL_COUNT_RST;
         cfg_ff.tracks    <= TRACKS_RST;
         cfg_ff.sectors   <= SECTORS_RST;
         cfg_ff.same_rule <= SAME_RULE_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CYL_COUNT: cfg_ff.cyl_count <= csr_data;
            CSR_TRACKS:    cfg_ff.tracks    <= csr_data[TPC_W-1:0];
            CSR_SECTORS:   cfg_ff.sectors   <= csr_data[SPT_W-1:0];
            CSR_SAME_RULE: cfg_ff.same_rule <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign item.mode        = mode_type'(req_tdata[1:0]);
   assign item.cylinder    = req_tdata[13:2];
   assign item.track       = req_tdata[18:14];
   assign item.sector      = req_tdata[24:19];
   assign item.whole_track = req_tuser;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.outcome;
   assign rsp_tdata  = {rsp_res_ff.spare_sector, rsp_res_ff.spare_track,
                        rsp_res_ff.spare_cylinder, rsp_res_ff.collides};

   sas_engine #(
      .RELOC_CYLS  (RELOC_CYLS),
      .MAX_TRACKS  (MAX_TRACKS),
      .MAX_SECTORS (MAX_SECTORS),
      .ROWS        (ROWS),
      .RW          (RW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .item        (item),
      .slot_free   (slot_free),
      .res_load    (res_load),
      .res         (res),
      .mem_clear   (mem_clear),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   sas_row_mem #(
      .ROWS  (ROWS),
      .WIDTH (MAX_SECTORS),
      .AW    (RW)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: spare sector allocator testbench
// Drives clear, mark, collision check and replacement requests through the
// request stream under several drive geometries, including the smallest,
// the largest, oversized and zero-sector settings. A behavioral copy of the
// used-sector table predicts each response not given by a directed probe, and
// a scoreboard compares every response beat field by field, in order. The
// sender works in bursts and the receiver stalls on its own random schedule.
// ----------------------------------------------------------------------------
module tb_top;
   import sas_pkg::*;

   localparam int ROWS         = RELOC_CYLS_DEF * MAX_TRACKS_DEF;
   localparam int PHASES       = 10;
   localparam int RANDOM_ITEMS = 650;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      item_type   item;
      bit         typed;
      result_type result;
   } probe_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic [OUTCOME_W-1:0]  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   logic [63:0]      used_map [ROWS];
   logic [CYL_W-1:0] cfg_cyls;
   logic [TPC_W-1:0] cfg_tracks;
   logic [SPT_W-1:0] cfg_sectors;
   logic             cfg_same;

   result_type pending_results [$];
   item_type   last_grant;
   int         mismatches   = 0;
   int         burst_left   = 0;
   int         ready_run    = 0;
   int         quiet_cycles = 0;

   spare_sector_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int tracks_in_use();
      return (cfg_tracks > MAX_TRACKS_DEF) ? MAX_TRACKS_DEF : int'(cfg_tracks);
   endfunction

   function automatic int sectors_in_use();
      return (cfg_sectors > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : int'(cfg_sectors);
   endfunction

   function automatic logic [63:0] full_track();
      int n;
      n = sectors_in_use();
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic int area_base();
      return int'(cfg_cyls) - SYSTEM_CYLS;
   endfunction

   function automatic int row_of(logic [CYL_W-1:0] cyl, logic [TRK_W-1:0] trk);
      int rel;
      rel = int'(cyl) - area_base();
      if (rel < 0 || rel >= RELOC_CYLS_DEF || int'(trk) >= tracks_in_use())
         return -1;
      return rel * tracks_in_use() + int'(trk);
   endfunction

   function automatic void mark_spare(item_type it);
      int r;
      r = row_of(it.cylinder, it.track);
      if (r < 0)
         return;
      if (it.whole_track)
         used_map[r] |= full_track();
      else
         used_map[r][it.sector] = 1'b1;
   endfunction

   function automatic result_type spare_at(int r, int s);
      result_type res;
      int cyl;
      cyl = r / tracks_in_use() + area_base();
      res = '0;
      res.outcome        = OUT_SPARE;
      res.spare_cylinder = cyl[CYL_W-1:0];
      res.spare_track    = TRK_W'(r % tracks_in_use());
      res.spare_sector   = SEC_W'(s);
      return res;
   endfunction

   function automatic result_type serve_request(item_type it);
      result_type  res;
      int          r;
      int          cyl;
      int          maint_cyl;
      int          nrows;
      int          nsec;
      logic [63:0] full;
      res       = '0;
      res.outcome = OUT_DONE;
      cyl       = int'(it.cylinder);
      maint_cyl = int'(cfg_cyls) - MAP_CYLS - MAINT_CYLS;
      nrows     = tracks_in_use() * RELOC_CYLS_DEF;
      nsec      = sectors_in_use();
      full      = full_track();
      case (it.mode)
         MODE_CLEAR: begin
            foreach (used_map[i])
               used_map[i] = '0;
         end
         MODE_MARK: begin
            mark_spare(it);
         end
         MODE_CHECK: begin
            r = row_of(it.cylinder, it.track);
            if (r >= 0)
               res.collides = it.whole_track ? |(used_map[r] & full)
                                             : used_map[r][it.sector];
         end
         default: begin
            res.spare_cylinder = it.cylinder;
            res.spare_track    = it.track;
            res.spare_sector   = it.sector;
            if (cyl >= area_base() && cyl < maint_cyl) begin
               mark_spare(it);
               res.outcome = OUT_IN_PLACE;
               return res;
            end
            if (cyl >= area_base() && cyl != maint_cyl) begin
               res.outcome = OUT_MAP;
               return res;
            end
            for (int i = 0; i < nrows; i++) begin
               if (it.whole_track) begin
                  if ((used_map[i] & full) == '0) begin
                     used_map[i] |= full;
                     return spare_at(i, 0);
                  end
               end else if (cfg_same) begin
                  if (!used_map[i][it.sector]) begin
                     used_map[i][it.sector] = 1'b1;
                     return spare_at(i, int'(it.sector));
                  end
               end else begin
                  for (int s = 0; s < nsec; s++) begin
                     if (!used_map[i][s]) begin
                        used_map[i][s] = 1'b1;
                        return spare_at(i, s);
                     end
                  end
               end
            end
            res = '0;
            res.outcome = OUT_NONE;
         end
      endcase
      return res;
   endfunction

   function automatic probe_type probe(mode_type m, int c, int t, int s, bit w, bit typed,
                                       outcome_type o, bit col, int sc, int st, int ss);
      probe_type p;
      p.item.mode                 = m;
      p.item.cylinder             = CYL_W'(c);
      p.item.track                = TRK_W'(t);
      p.item.sector               = SEC_W'(s);
      p.item.whole_track          = w;
      p.typed                     = typed;
      p.result.outcome            = o;
      p.result.collides           = col;
      p.result.spare_cylinder     = CYL_W'(sc);
      p.result.spare_track        = TRK_W'(st);
      p.result.spare_sector       = SEC_W'(ss);
      return p;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int       pick;
      int       base;
      pick = $urandom_range(99);
      it.mode = (pick < 3)  ? MODE_CLEAR :
                (pick < 28) ? MODE_MARK  :
                (pick < 58) ? MODE_CHECK : MODE_REPLACE;
      it.whole_track = ($urandom_range(3) == 0);
      base = area_base();
      pick = $urandom_range(99);
      if (it.mode == MODE_REPLACE && pick < 70)
         it.cylinder = (base > 0) ? CYL_W'($urandom_range(base - 1)) : CYL_W'($urandom);
      else if (pick < 90)
         it.cylinder = CYL_W'(base - 1 + int'($urandom_range(5)));
      else
         it.cylinder = CYL_W'($urandom);
      it.track = ($urandom_range(99) < 85) ? TRK_W'($urandom_range(tracks_in_use() - 1))
                                           : TRK_W'($urandom_range(31));
      if (sectors_in_use() > 0 && $urandom_range(99) < 80)
         it.sector = SEC_W'($urandom_range(sectors_in_use() - 1));
      else
         it.sector = SEC_W'($urandom_range(63));
      if (it.mode != MODE_REPLACE && it.mode != MODE_CLEAR && $urandom_range(99) < 35) begin
         it.cylinder = last_grant.cylinder;
         it.track    = last_grant.track;
         it.sector   = last_grant.sector;
      end
      return it;
   endfunction

   task automatic send_request(item_type it, bit typed, result_type typed_res);
      result_type predicted;
      int         roll;
      int         idle;
      req_tdata  <= {7'd0, it.sector, it.track, it.cylinder, it.mode};
      req_tuser  <= it.whole_track;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = serve_request(it);
      pending_results.push_back(typed ? typed_res : predicted);
      if (predicted.outcome == OUT_SPARE || predicted.outcome == OUT_IN_PLACE) begin
         last_grant.cylinder = predicted.spare_cylinder;
         last_grant.track    = predicted.spare_track;
         last_grant.sector   = predicted.spare_sector;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         roll = $urandom_range(99);
         idle = (roll < 40) ? 0 :
                (roll < 75) ? $urandom_range(3, 1) :
                (roll < 93) ? $urandom_range(20, 4) : $urandom_range(150, 21);
         burst_left = ($urandom_range(99) < 10) ? $urandom_range(30, 10) : $urandom_range(4);
         if (idle > 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_regs(int cyls, int tracks, int sectors, int same);
      csr_index_type         regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs = '{CSR_CYL_COUNT, CSR_TRACKS, CSR_SECTORS, CSR_SAME_RULE};
      vals[0] = CSR_DATA_W'(cyls);
      vals[1] = CSR_DATA_W'(tracks);
      vals[2] = CSR_DATA_W'(sectors);
      vals[3] = CSR_DATA_W'(same);
      for (int i = 0; i < 4; i++) begin
         csr_index <= regs[i];
         csr_data  <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            CSR_CYL_COUNT: cfg_cyls    = vals[i][CYL_W-1:0];
            CSR_TRACKS:    cfg_tracks  = vals[i][TPC_W-1:0];
            CSR_SECTORS:   cfg_sectors = vals[i][SPT_W-1:0];
            CSR_SAME_RULE: cfg_same    = vals[i][0];
            default:       ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic choose_geometry(int p);
      case (p)
         0:       program_regs(823, 19, 32, 1);
         1:       program_regs(8, 1, 1, 0);
         2:       program_regs(4095, 32, 64, 0);
         3:       program_regs(3, 63, 127, 1);
         4:       program_regs(100, 5, 0, 0);
         5:       program_regs(9, 2, 2, 1);
         6:       program_regs(4, 40, 70, 0);
         default: program_regs($urandom_range(4095, 8), $urandom_range(32, 1),
                               $urandom_range(64), $urandom_range(1));
      endcase
   endtask

   task automatic report(bit unexpected, result_type want, result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (unexpected)
            $display("unexpected response: outcome %0d collides %0d addr %0d/%0d/%0d",
                     got.outcome, got.collides, got.spare_cylinder, got.spare_track,
                     got.spare_sector);
         else
            $display("mismatch: expected outcome %0d collides %0d addr %0d/%0d/%0d, got %0d %0d %0d/%0d/%0d",
                     want.outcome, want.collides, want.spare_cylinder, want.spare_track,
                     want.spare_sector, got.outcome, got.collides, got.spare_cylinder,
                     got.spare_track, got.spare_sector);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.outcome        = outcome_type'(rsp_tuser);
         got.collides       = rsp_tdata[0];
         got.spare_cylinder = rsp_tdata[12:1];
         got.spare_track    = rsp_tdata[17:13];
         got.spare_sector   = rsp_tdata[23:18];
         if (pending_results.size() == 0) begin
            report(1'b1, '0, got);
         end else begin
            want = pending_results.pop_front();
            bad = (got.outcome !== want.outcome) || (got.collides !== want.collides) ||
                  (got.spare_cylinder !== want.spare_cylinder) ||
                  (got.spare_track !== want.spare_track) ||
                  (got.spare_sector !== want.spare_sector);
            if (bad)
               report(1'b0, want, got);
         end
      end
   end

   // stall the response beat on a schedule of its own
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(99);
      if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else if (roll < 8) begin
         rsp_tready <= 1'b1;
         ready_run  <= $urandom_range(600, 200);
      end else if (roll < 50) begin
         rsp_tready <= 1'b0;
         ready_run  <= (roll < 45) ? $urandom_range(8) : $urandom_range(200, 40);
      end else begin
         rsp_tready <= 1'b1;
         ready_run  <= $urandom_range(12);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      probe_type probes [$];
      foreach (used_map[i])
         used_map[i] = '0;
      cfg_cyls    = CYL_COUNT_RST;
      cfg_tracks  = TRACKS_RST;
      cfg_sectors = SECTORS_RST;
      cfg_same    = SAME_RULE_RST;
      last_grant  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      probes.push_back(probe(MODE_CHECK,   818,  0,  0, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_REPLACE, 100,  3,  5, 0, 1, OUT_SPARE,    0,  818,  0,  0));
      probes.push_back(probe(MODE_REPLACE, 100,  3,  5, 0, 1, OUT_SPARE,    0,  818,  0,  1));
      probes.push_back(probe(MODE_CHECK,   818,  0,  1, 0, 1, OUT_DONE,     1,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   818,  0,  2, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_REPLACE, 100,  3,  0, 1, 1, OUT_SPARE,    0,  818,  1,  0));
      probes.push_back(probe(MODE_MARK,    819, 18, 63, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   819, 18, 63, 0, 1, OUT_DONE,     1,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   819, 19,  0, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_MARK,   4095, 31, 63, 1, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,  4095, 31, 63, 1, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   817,  0,  0, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_REPLACE, 820,  5,  7, 0, 1, OUT_IN_PLACE, 0,  820,  5,  7));
      probes.push_back(probe(MODE_CHECK,   820,  5,  7, 0, 1, OUT_DONE,     1,    0,  0,  0));
      probes.push_back(probe(MODE_REPLACE, 822,  2,  3, 0, 1, OUT_MAP,      0,  822,  2,  3));
      probes.push_back(probe(MODE_REPLACE,4095, 31, 63, 1, 1, OUT_MAP,      0, 4095, 31, 63));
      probes.push_back(probe(MODE_REPLACE, 821,  0,  0, 0, 1, OUT_SPARE,    0,  818,  0,  2));
      probes.push_back(probe(MODE_REPLACE,   0,  0,  0, 1, 0, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_MARK,    820, 18,  0, 0, 0, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CLEAR,     0,  0,  0, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   818,  0,  0, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_MARK,    818,  0,  0, 1, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   818,  0,  5, 0, 1, OUT_DONE,     1,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   818,  0, 40, 0, 1, OUT_DONE,     0,    0,  0,  0));
      probes.push_back(probe(MODE_CHECK,   818,  1,  0, 1, 1, OUT_DONE,     0,    0,  0,  0));

      foreach (probes[i])
         send_request(probes[i].item, probes[i].typed, probes[i].result);
      finish_phase();

      for (int p = 0; p < PHASES; p++) begin
         choose_geometry(p);
         repeat (RANDOM_ITEMS / PHASES)
            send_request(random_item(), 1'b0, '0);
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
